// File: src/adq_pkg.sv
// Shared types, constants and register codes for the audio decimator.
package adq_pkg;

  localparam int LEVEL_BITS          = 5;
  localparam int PHASE_FRACTION_BITS = 16;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 16;
  localparam int LIMIT_W   = 24;
  localparam int CHAN_W    = 4;
  localparam int INDEX_W   = 3;
  localparam int PHASE_W   = PHASE_FRACTION_BITS + 1;
  localparam int PSUM_W    = ((PHASE_W + 1) > (STEP_W + 1)) ? (PHASE_W + 1) : (STEP_W + 1);
  localparam int SUM_W     = 33;
  localparam int COUNT_W   = 17;
  localparam int DIVIDEND_W = SUM_W - 1;
  localparam int DIV_CNT_W = $clog2(DIVIDEND_W);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRACTION_BITS;
  localparam logic [PHASE_W-1:0] PHASE_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CHAN_W-1:0]  CHAN_MAX  = CHAN_W'(8);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_FORMAT   = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_STEP     = 3'd2,
    REG_LIMIT    = 3'd3,
    REG_AVERAGE  = 3'd4,
    REG_HALFBAND = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic               sample_format;
    logic [CHAN_W-1:0]  num_channels;
    logic [STEP_W-1:0]  phase_step;
    logic [LIMIT_W-1:0] output_limit;
    logic               average_enable;
    logic               halfband_enable;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic use_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: src/audio_decimator_5bit_quantizer.sv
// Top level: register port, control state machine and datapath.
// Takes one interleaved sample word per handshake and uses only the first
// channel of each frame. A word that produces no level leaves the block
// idle. An emitted level goes through the finish state, with averaging
// first through the 32-step serial divider that forms the boxcar
// mean. The level sits in an output register, so the next sample word is
// taken while it waits. Registers (4-byte stride): format, channels, phase
// step, output limit, average enable, half-band enable; write them only
// while the block is idle.
module audio_decimator_5bit_quantizer import adq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  sample_valid_i,
  output logic                  sample_ready_o,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  level_valid_o,
  input  logic                  level_ready_i
);

  cfg_t       cfg_q, cfg_d;
  cmd_t       cmd;
  status_t    status;
  reg_index_e reg_idx;
  logic       wr_en;

  assign reg_idx = reg_index_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FORMAT:   cfg_d.sample_format   = pwdata[0];
        REG_CHANNELS: cfg_d.num_channels    = pwdata[CHAN_W-1:0];
        REG_STEP:     cfg_d.phase_step      = pwdata[STEP_W-1:0];
        REG_LIMIT:    cfg_d.output_limit    = pwdata[LIMIT_W-1:0];
        REG_AVERAGE:  cfg_d.average_enable  = pwdata[0];
        REG_HALFBAND: cfg_d.halfband_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_FORMAT:   prdata = PDATA_W'(cfg_q.sample_format);
      REG_CHANNELS: prdata = PDATA_W'(cfg_q.num_channels);
      REG_STEP:     prdata = PDATA_W'(cfg_q.phase_step);
      REG_LIMIT:    prdata = PDATA_W'(cfg_q.output_limit);
      REG_AVERAGE:  prdata = PDATA_W'(cfg_q.average_enable);
      REG_HALFBAND: prdata = PDATA_W'(cfg_q.halfband_enable);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format   <= 1'b1;
      cfg_q.num_channels    <= CHAN_W'(1);
      cfg_q.phase_step      <= STEP_W'(8192);
      cfg_q.output_limit    <= '1;
      cfg_q.average_enable  <= 1'b0;
      cfg_q.halfband_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  adq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  adq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i),
    .level_valid_o (level_valid_o),
    .level_ready_i (level_ready_i),
    .level_o       (level_o)
  );

endmodule

// File: src/adq_div.sv
// Serial restoring divider, one quotient bit per cycle.
module adq_div import adq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [COUNT_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [COUNT_W-1:0]    remainder_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [COUNT_W-1:0]    rem_q, rem_d;
  logic [COUNT_W-1:0]    dsr_q, dsr_d;
  logic [COUNT_W:0]      trial;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? COUNT_W'(trial - {1'b0, dsr_q}) : trial[COUNT_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: src/adq_dp.sv
// Datapath: frame position, phase, boxcar sum, half-band filter and output word.
module adq_dp import adq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  level_valid_o,
  input  logic                  level_ready_i,
  output logic [LEVEL_BITS-1:0] level_o
);

  logic [INDEX_W-1:0]       idx_q, idx_d;
  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic [LIMIT_W-1:0]       emitted_q, emitted_d;
  logic                     out_valid_q, out_valid_d;
  logic [LEVEL_BITS-1:0]    level_q, level_d;
  logic signed [SAMPLE_W-1:0] v_q, v_d;
  logic                     neg_q, neg_d;

  logic [CHAN_W-1:0]        n_eff;
  logic [CHAN_W-1:0]        idx_inc;
  logic                     first;
  logic signed [SAMPLE_W-1:0] s;
  logic [PSUM_W-1:0]        psum;
  logic [PHASE_W-1:0]       phase_new;
  logic                     grow;
  logic signed [SUM_W-1:0]  sum_new;
  logic [COUNT_W-1:0]       count_new;
  logic                     emit;
  logic                     use_div;
  logic [SUM_W-1:0]         sum_abs;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    quo;
  logic [COUNT_W-1:0]       rem;
  logic signed [COUNT_W:0]  qmag;
  logic signed [COUNT_W:0]  mean;
  logic signed [SAMPLE_W:0] pair;
  logic signed [SAMPLE_W-1:0] v_out;
  logic [SAMPLE_W-1:0]      v_bias;
  logic                     out_free;

  always_comb begin
    if (cfg_i.num_channels == '0) begin
      n_eff = CHAN_W'(1);
    end else if (cfg_i.num_channels > CHAN_MAX) begin
      n_eff = CHAN_MAX;
    end else begin
      n_eff = cfg_i.num_channels;
    end
  end

  assign idx_inc = CHAN_W'(idx_q) + 1'b1;
  assign first   = (idx_q == '0);

  assign s = cfg_i.sample_format ? $signed(sample_i)
                                 : $signed({~sample_i[7], sample_i[6:0], 8'h00});

  assign psum      = PSUM_W'(phase_q) + PSUM_W'(cfg_i.phase_step);
  assign phase_new = (psum > PSUM_W'(PHASE_MAX)) ? PHASE_MAX : psum[PHASE_W-1:0];

  assign grow      = cfg_i.average_enable && (count_q < COUNT_MAX);
  assign sum_new   = grow ? (sum_q + SUM_W'(s)) : sum_q;
  assign count_new = grow ? (count_q + 1'b1) : count_q;

  assign emit    = first && (phase_new >= PHASE_ONE) && (emitted_q < cfg_i.output_limit);
  assign use_div = cfg_i.average_enable && (count_new != '0);

  assign sum_abs = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  adq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (sum_abs[DIVIDEND_W-1:0]),
    .divisor_i   (count_new),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign qmag = $signed({1'b0, quo[COUNT_W-1:0]});
  assign mean = neg_q ? (-qmag - ((rem != '0) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(0))) : qmag;

  assign pair   = (SAMPLE_W+1)'(v_q) + (SAMPLE_W+1)'(prev_q);
  assign v_out  = cfg_i.halfband_enable ? pair[SAMPLE_W:1] : v_q;
  assign v_bias = v_out ^ {1'b1, {(SAMPLE_W-1){1'b0}}};

  assign out_free = !out_valid_q || level_ready_i;

  always_comb begin
    idx_d       = idx_q;
    phase_d     = phase_q;
    sum_d       = sum_q;
    count_d     = count_q;
    prev_d      = prev_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    v_d         = v_q;
    neg_d       = neg_q;
    if (out_valid_q && level_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.accept) begin
      idx_d = (idx_inc >= n_eff) ? '0 : idx_inc[INDEX_W-1:0];
      if (first) begin
        phase_d = phase_new;
        sum_d   = sum_new;
        count_d = count_new;
        v_d     = s;
        if (emit && cfg_i.average_enable) begin
          sum_d   = '0;
          count_d = '0;
        end
      end
    end
    if (cmd_i.div_start) begin
      neg_d = sum_new[SUM_W-1];
    end
    if (div_done) begin
      v_d = mean[SAMPLE_W-1:0];
    end
    if (cmd_i.finish) begin
      if (cfg_i.halfband_enable) begin
        prev_d = v_q;
      end
      level_d     = v_bias[SAMPLE_W-1 -: LEVEL_BITS];
      out_valid_d = 1'b1;
      emitted_d   = emitted_q + 1'b1;
      phase_d     = phase_q - PHASE_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      phase_q     <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      prev_q      <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      prev_q      <= prev_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    v_q     <= v_d;
    neg_q   <= neg_d;
  end

  assign status_o.emit     = emit;
  assign status_o.use_div  = use_div;
  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;

  assign level_valid_o = out_valid_q;
  assign level_o       = level_q;

endmodule

// File: src/adq_ctrl.sv
// Control state machine: accept, divide, finish.
module adq_ctrl import adq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    sample_valid_i,
  output logic    sample_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = (state_q == ST_IDLE) && sample_valid_i;

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.finish    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = accept;
        if (accept && status_i.emit) begin
          if (status_i.use_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign sample_ready_o = (state_q == ST_IDLE);

endmodule
